[sv/mns_pkg.sv]
// Package: shared constants and the gate ratio function of the note sequencer.
package mns_pkg;
    localparam int KIND_W = 3;
    localparam logic [KIND_W-1:0] KIND_LOAD  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_TICK  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PLAY  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_PAUSE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RESET = 3'd4;
    localparam logic [1:0] REG_TRACK_COUNT = 2'd0;
    localparam logic [1:0] REG_SONG_LENGTH = 2'd1;
    localparam logic [1:0] REG_LOOP_START  = 2'd2;
    localparam logic [1:0] REG_LOOP_LIMIT  = 2'd3;
    localparam int NOTE_W = 50;
    localparam logic [7:0] LOOP_FOREVER = 8'd255;

    function automatic logic [8:0] gate_ratio(input logic [1:0] art);
        case (art)
            2'd0:    gate_ratio = 9'd256;
            2'd2:    gate_ratio = 9'd38;
            default: gate_ratio = 9'd218;
        endcase
    endfunction
endpackage

[sv/mns_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
module mns_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

[sv/multitrack_note_sequencer.sv]
// Top level: multi-track note sequencer with event tables in RAM.
// Loads, play, pause and reset pass through a decode state and give no result. A tick
// walks the tracks in use one at a time through a sequencer that reads the
// event table (registered RAM reads): per track it reads the next event and
// advances while the song time is past its start, then reads the current event
// and applies the gate test, and an empty track gives a silent result; a song-end
// loop first re-seeks each track to its first event not before loop start.
// Results leave through an output register; the walk holds while it waits
// there. Event slots that were never loaded read as undefined.
module multitrack_note_sequencer
    import mns_pkg::*;
#(
    parameter int TRACKS = 8,
    parameter int EVENTS_PER_TRACK = 256
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // kind[2:0] track_select[5:3] event_index[13:6] event_start[45:14]
    // event_key[61:46] event_dynamic[77:62] event_panning[85:78]
    // event_timbre[93:86] event_articulation[95:94] time_step[111:96]
    input  logic [111:0] s_tdata,
    input  logic         s_tlast,    // event_last
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_track[2:0] note_key[18:3] note_dynamic[34:19] note_panning[42:35]
    // note_timbre[50:43] note_silent[51] is_playing[52] has_played[53]
    output logic [55:0]  m_tdata,
    output logic         m_tlast,    // run_last
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_wdata
);
    localparam int TW = (TRACKS > 1) ? $clog2(TRACKS) : 1;
    localparam int EW = $clog2(EVENTS_PER_TRACK);
    localparam int AW = $clog2(TRACKS * EVENTS_PER_TRACK);
    localparam int CW = EW + 1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DECODE, ST_SEEK_RD, ST_SEEK_CHK, ST_TRK_START, ST_RD_NEXT,
        ST_CHK_NEXT, ST_RD_CUR, ST_GATE, ST_EMIT
    } state_t;

    state_t state_reg;
    logic [111:0] in_reg;
    logic in_last_reg;
    logic [3:0]  track_count_reg;
    logic [31:0] song_length_reg, loop_start_reg;
    logic [7:0]  loop_limit_reg;
    logic [CW-1:0] count_reg [TRACKS];
    logic [EW-1:0] pos_reg [TRACKS];
    logic [31:0] play_time_reg;
    logic [7:0]  loops_reg;
    logic playing_reg, played_reg;
    logic [TW-1:0] trk_reg;
    logic [EW-1:0] p_reg;
    logic [31:0] nx_reg;
    logic [6:0]  n_reg;

    // input field views
    logic [2:0] f_kind, f_track;
    logic [7:0] f_index;
    logic [31:0] f_start;
    logic [NOTE_W-1:0] f_note;
    logic [15:0] f_step;
    assign f_kind  = in_reg[2:0];
    assign f_track = in_reg[5:3];
    assign f_index = in_reg[13:6];
    assign f_start = in_reg[45:14];
    assign f_note  = in_reg[95:46];
    assign f_step  = in_reg[111:96];

    // RAM ports
    logic ram_we;
    logic [AW-1:0] waddr, raddr;
    logic [EW-1:0] rd_idx;
    logic [31:0] start_q;
    logic [NOTE_W-1:0] note_q;
    logic load_ok;

    assign load_ok = (32'(f_track) < 32'(TRACKS)) && (32'(f_index) < 32'(EVENTS_PER_TRACK));
    assign ram_we = (state_reg == ST_DECODE) && (f_kind == KIND_LOAD) && load_ok;
    assign waddr = AW'((32'(f_track) * 32'(EVENTS_PER_TRACK)) + 32'(f_index));
    assign raddr = AW'((32'(trk_reg) * 32'(EVENTS_PER_TRACK)) + 32'(rd_idx));

    mns_ram #(.WIDTH(32), .DEPTH(TRACKS * EVENTS_PER_TRACK)) u_starts (
        .aclk(aclk), .we(ram_we), .waddr(waddr), .wdata(f_start),
        .raddr(raddr), .rdata(start_q));
    mns_ram #(.WIDTH(NOTE_W), .DEPTH(TRACKS * EVENTS_PER_TRACK)) u_notes (
        .aclk(aclk), .we(ram_we), .waddr(waddr), .wdata(f_note),
        .raddr(raddr), .rdata(note_q));

    logic [6:0] n_use;
    assign n_use = (32'(track_count_reg) > 32'(TRACKS)) ? 7'(TRACKS) : 7'(track_count_reg);

    logic [CW-1:0] cnt;
    logic [EW-1:0] lastp;
    logic at_last;
    assign cnt = count_reg[trk_reg];
    assign lastp = EW'(cnt - CW'(1));
    assign at_last = (p_reg >= lastp);

    // read index: next event while advancing, current otherwise
    always_comb begin
        case (state_reg)
            ST_RD_NEXT: rd_idx = p_reg + EW'(1);
            default:    rd_idx = p_reg;
        endcase
    end

    // gate test: t*256 > s*256 + (nx-s)*ratio
    logic signed [33:0] span;
    logic signed [43:0] rhs, lhs;
    logic silent_c;
    assign span = $signed({2'b0, nx_reg}) - $signed({2'b0, start_q});
    assign rhs = $signed({4'b0, start_q, 8'b0}) + span * $signed({1'b0, gate_ratio(note_q[49:48])});
    assign lhs = $signed({4'b0, play_time_reg, 8'b0});
    assign silent_c = lhs > rhs;

    logic [32:0] sum;
    assign sum = {1'b0, play_time_reg} + 33'(f_step);

    assign s_tready = (state_reg == ST_IDLE);

    // load the output register when a result is ready and the slot is free
    logic emit_fire;
    assign emit_fire = (state_reg inside {ST_GATE, ST_EMIT}) && (!m_tvalid || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            m_tvalid <= 1'b0;
            track_count_reg <= '0; song_length_reg <= '0;
            loop_start_reg <= '0; loop_limit_reg <= '0;
            for (int i = 0; i < TRACKS; i++) begin
                count_reg[i] <= '0; pos_reg[i] <= '0;
            end
            play_time_reg <= '0; loops_reg <= '0;
            playing_reg <= 1'b0; played_reg <= 1'b0;
            trk_reg <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_TRACK_COUNT: track_count_reg <= cfg_wdata[3:0];
                    REG_SONG_LENGTH: song_length_reg <= cfg_wdata;
                    REG_LOOP_START:  loop_start_reg  <= cfg_wdata;
                    REG_LOOP_LIMIT:  loop_limit_reg  <= cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (emit_fire) m_tvalid <= 1'b1;
            else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        in_reg <= s_tdata; in_last_reg <= s_tlast;
                        state_reg <= ST_DECODE;
                    end
                end
                ST_DECODE: begin
                    state_reg <= ST_IDLE;
                    trk_reg <= '0;
                    n_reg <= n_use;
                    case (f_kind)
                        KIND_LOAD: if (load_ok && in_last_reg)
                            count_reg[TW'(f_track)] <= CW'(f_index) + CW'(1);
                        KIND_PLAY:  playing_reg <= 1'b1;
                        KIND_PAUSE: playing_reg <= 1'b0;
                        KIND_RESET: begin
                            play_time_reg <= '0;
                            for (int i = 0; i < TRACKS; i++) pos_reg[i] <= '0;
                        end
                        KIND_TICK: begin
                            logic [31:0] pt;
                            logic [7:0] ld;
                            pt = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                            ld = (loops_reg != 8'd255) ? loops_reg + 8'd1 : loops_reg;
                            state_reg <= (n_use == 7'd0) ? ST_IDLE : ST_TRK_START;
                            if (playing_reg) begin
                                play_time_reg <= pt;
                                if (pt > song_length_reg) begin
                                    played_reg <= 1'b1;
                                    loops_reg <= ld;
                                    if (ld < loop_limit_reg || loop_limit_reg == LOOP_FOREVER) begin
                                        play_time_reg <= loop_start_reg;
                                        p_reg <= '0;
                                        state_reg <= (n_use == 7'd0) ? ST_IDLE : ST_SEEK_RD;
                                    end else begin
                                        playing_reg <= 1'b0;
                                    end
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                // re-seek each track to its first event not before loop start
                ST_SEEK_RD: begin
                    if (cnt == '0) begin
                        pos_reg[trk_reg] <= '0;
                        if (7'(trk_reg) + 7'd1 == n_reg) begin
                            trk_reg <= '0; state_reg <= ST_TRK_START;
                        end else trk_reg <= trk_reg + TW'(1);
                    end else state_reg <= ST_SEEK_CHK;
                end
                ST_SEEK_CHK: begin
                    if (!at_last && loop_start_reg > start_q) begin
                        p_reg <= p_reg + EW'(1); state_reg <= ST_SEEK_RD;
                    end else begin
                        pos_reg[trk_reg] <= p_reg; p_reg <= '0;
                        state_reg <= ST_SEEK_RD;
                        if (7'(trk_reg) + 7'd1 == n_reg) begin
                            trk_reg <= '0; state_reg <= ST_TRK_START;
                        end else trk_reg <= trk_reg + TW'(1);
                    end
                end
                ST_TRK_START: begin
                    if (cnt == '0) begin
                        state_reg <= ST_EMIT;
                    end else begin
                        p_reg <= (pos_reg[trk_reg] > lastp) ? lastp : pos_reg[trk_reg];
                        state_reg <= ST_RD_NEXT;
                    end
                end
                ST_RD_NEXT: begin
                    if (at_last) begin
                        nx_reg <= song_length_reg;
                        state_reg <= ST_RD_CUR;
                    end else state_reg <= ST_CHK_NEXT;
                end
                ST_CHK_NEXT: begin
                    nx_reg <= start_q;
                    if (play_time_reg > start_q) begin
                        p_reg <= p_reg + EW'(1);
                        state_reg <= ST_RD_NEXT;
                    end else state_reg <= ST_RD_CUR;
                end
                ST_RD_CUR: begin
                    pos_reg[trk_reg] <= p_reg;
                    state_reg <= ST_GATE;
                end
                ST_GATE, ST_EMIT: begin
                    if (emit_fire) begin
                        logic sil;
                        sil = (state_reg == ST_EMIT) ? 1'b1 : silent_c;
                        m_tdata <= {2'b0, played_reg, playing_reg, sil,
                                    sil ? 48'd0 : note_q[47:0], 3'(trk_reg)};
                        m_tlast <= (7'(trk_reg) + 7'd1 == n_reg);
                        if (7'(trk_reg) + 7'd1 == n_reg) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            trk_reg <= trk_reg + TW'(1);
                            state_reg <= ST_TRK_START;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

[verif/tb_multitrack_note_sequencer.sv]
// Testbench: stream-driven checking of the multi-track note sequencer.
module tb_multitrack_note_sequencer
    import mns_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NTRK = 8;
    localparam int NEVT = 256;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [111:0] s_tdata = '0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [55:0]  m_tdata;
    logic         m_tlast;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_index = '0;
    logic [31:0]  cfg_wdata = '0;

    multitrack_note_sequencer #(.TRACKS(NTRK), .EVENTS_PER_TRACK(NEVT)) dut (.*);

    // one input request, as a packed struct of its fields
    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  trk;
        logic [7:0]  idx;
        logic [31:0] start;
        logic [15:0] key;
        logic [15:0] dyn;
        logic [7:0]  pan;
        logic [7:0]  timbre;
        logic [1:0]  art;
        logic        last;
        logic [15:0] step;
    } seq_req_t;

    typedef struct packed {
        logic [2:0]  trk;
        logic [15:0] key;
        logic [15:0] dyn;
        logic [7:0]  pan;
        logic [7:0]  timbre;
        logic        silent;
        logic        playing;
        logic        played;
        logic        last;
    } note_rpt_t;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // predictor state
    logic [31:0] ev_start [NTRK][NEVT];
    logic [49:0] ev_note  [NTRK][NEVT];
    int unsigned ev_count [NTRK];
    int unsigned ev_pos   [NTRK];
    logic [31:0] song_time;
    int unsigned loops;
    bit          playing, played;
    int unsigned cur_tracks;
    logic [31:0] cur_len, cur_loop_start;
    logic [7:0]  cur_limit;

    seq_req_t    pending_reqs[$];
    note_rpt_t   expected_notes[$];
    int          errors = 0;

    // record of which slots hold data, so nothing undefined is read
    bit          written [NTRK][NEVT];

    function automatic logic [8:0] ratio_of(input logic [1:0] a);
        if (a == 2'd0) return 9'd256;
        if (a == 2'd2) return 9'd38;
        return 9'd218;
    endfunction

    task automatic reseek_track(input int t);
        int unsigned p;
        p = 0;
        if (ev_count[t] > 0)
            while (p < ev_count[t] - 1 && cur_loop_start > ev_start[t][p]) p++;
        ev_pos[t] = p;
    endtask

    task automatic predict_notes(input seq_req_t r);
        longint unsigned sum;
        int unsigned p, c, ntr;
        logic [31:0] s, nx;
        logic [49:0] nt;
        longint lhs, rhs;
        note_rpt_t o;
        case (r.kind)
            KIND_LOAD: begin
                ev_start[r.trk][r.idx] = r.start;
                ev_note[r.trk][r.idx] = {r.art, r.timbre, r.pan, r.dyn, r.key};
                if (r.last) ev_count[r.trk] = r.idx + 1;
            end
            KIND_PLAY:  playing = 1;
            KIND_PAUSE: playing = 0;
            KIND_RESET: begin
                song_time = 0;
                foreach (ev_pos[t]) ev_pos[t] = 0;
            end
            KIND_TICK: begin
                ntr = cur_tracks > NTRK ? NTRK : cur_tracks;
                if (playing) begin
                    sum = song_time + r.step;
                    song_time = sum > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : sum[31:0];
                    if (song_time > cur_len) begin
                        played = 1;
                        if (loops < 255) loops++;
                        if (loops < cur_limit || cur_limit == LOOP_FOREVER) begin
                            song_time = cur_loop_start;
                            for (int t = 0; t < ntr; t++) reseek_track(t);
                        end else playing = 0;
                    end
                end
                for (int t = 0; t < ntr; t++) begin
                    o = '0;
                    o.trk = 3'(t);
                    o.silent = 1;
                    c = ev_count[t];
                    if (c > 0) begin
                        p = ev_pos[t] > c - 1 ? c - 1 : ev_pos[t];
                        nx = (p < c - 1) ? ev_start[t][p+1] : cur_len;
                        while (song_time > nx && p < c - 1) begin
                            p++;
                            nx = (p < c - 1) ? ev_start[t][p+1] : cur_len;
                        end
                        ev_pos[t] = p;
                        s = ev_start[t][p];
                        nt = ev_note[t][p];
                        lhs = longint'(song_time) * 256;
                        rhs = longint'(s) * 256 +
                              (longint'(nx) - longint'(s)) * longint'(ratio_of(nt[49:48]));
                        if (!(lhs > rhs)) begin
                            o.silent = 0;
                            o.key = nt[15:0];
                            o.dyn = nt[31:16];
                            o.pan = nt[39:32];
                            o.timbre = nt[47:40];
                        end
                    end
                    o.playing = playing;
                    o.played = played;
                    o.last = (t + 1 == ntr);
                    expected_notes.push_back(o);
                end
            end
            default: ;
        endcase
    endtask

    // remember whether the request on the bus was taken at the last edge
    bit s_acc = 0;
    always @(posedge aclk) s_acc <= s_tvalid && s_tready;

    // driver: bursts of requests with random gaps
    int burst_left = 0, gap_left = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && !s_acc) begin
                // hold the current request
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                seq_req_t r;
                r = pending_reqs.pop_front();
                s_tdata <= {r.step, r.art, r.timbre, r.pan, r.dyn, r.key, r.start,
                            r.idx, r.trk, r.kind};
                s_tlast <= r.last;
                s_tvalid <= 1'b1;
                predict_notes(r);
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end else burst_left--;
            end else s_tvalid <= 1'b0;
        end
    end

    // receiver stall pattern: alternating ready and stall windows
    int stall_ctr = 0;
    bit stall_mode = 0;
    always @(negedge aclk) begin
        if (stall_ctr == 0) begin
            stall_mode = ~stall_mode;
            stall_ctr = stall_mode ? $urandom_range(0, 6) : $urandom_range(1, 30);
        end else stall_ctr--;
        m_tready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
    end

    // monitor: compare each result with the oldest expected note
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            note_rpt_t e, a;
            a = {m_tdata[2:0], m_tdata[18:3], m_tdata[34:19], m_tdata[42:35],
                 m_tdata[50:43], m_tdata[51], m_tdata[52], m_tdata[53], m_tlast};
            if (expected_notes.size() == 0) begin
                $error("unexpected result %h", m_tdata);
                errors++;
            end else begin
                e = expected_notes.pop_front();
                if (a.trk != e.trk) begin
                    $error("out_track exp %0d got %0d", e.trk, a.trk); errors++; end
                if (a.key != e.key) begin
                    $error("note_key exp %h got %h", e.key, a.key); errors++; end
                if (a.dyn != e.dyn) begin
                    $error("note_dynamic exp %h got %h", e.dyn, a.dyn); errors++; end
                if (a.pan != e.pan) begin
                    $error("note_panning exp %h got %h", e.pan, a.pan); errors++; end
                if (a.timbre != e.timbre) begin
                    $error("note_timbre exp %h got %h", e.timbre, a.timbre); errors++; end
                if (a.silent != e.silent) begin
                    $error("note_silent exp %0d got %0d", e.silent, a.silent); errors++; end
                if (a.playing != e.playing) begin
                    $error("is_playing exp %0d got %0d", e.playing, a.playing); errors++; end
                if (a.played != e.played) begin
                    $error("has_played exp %0d got %0d", e.played, a.played); errors++; end
                if (a.last != e.last) begin
                    $error("run_last exp %0d got %0d", e.last, a.last); errors++; end
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_TRACK_COUNT: cur_tracks = val[3:0];
            REG_SONG_LENGTH: cur_len = val;
            REG_LOOP_START:  cur_loop_start = val;
            REG_LOOP_LIMIT:  cur_limit = val[7:0];
            default: ;
        endcase
    endtask

    // wait for idle: queue drained, all results in, then let the walk settle
    task automatic drain;
        while (pending_reqs.size() > 0 || s_tvalid || expected_notes.size() > 0)
            @(posedge aclk);
        repeat (1200) @(posedge aclk);
    endtask

    function automatic seq_req_t rand_req;
        seq_req_t r;
        r = seq_req_t'(112'({$urandom, $urandom, $urandom, $urandom}));
        return r;
    endfunction

    function automatic seq_req_t mk(input logic [2:0] k, input logic [15:0] st);
        seq_req_t r;
        r = rand_req();
        r.kind = k;
        r.step = st;
        return r;
    endfunction

    // queue a full track: rising starts (slot 2 may start earlier), every slot written, last marks count
    task automatic load_track(input int t, input int n, input logic [31:0] span, input bit ext);
        seq_req_t r;
        logic [31:0] st;
        st = ext ? 32'd0 : $urandom_range(0, 32'h3000);
        for (int i = 0; i < n; i++) begin
            r = rand_req();
            r.kind = KIND_LOAD;
            r.trk = 3'(t);
            r.idx = 8'(i);
            r.start = (i == 2 && $urandom_range(0, 3) == 0) ? st - 32'h100 : st;
            r.last = (i == n - 1);
            written[t][i] = 1;
            pending_reqs.push_back(r);
            st = st + $urandom_range(1, span);
        end
    endtask

    task automatic play_phase(input int ticks);
        seq_req_t r;
        pending_reqs.push_back(mk(KIND_PLAY, 16'd0));
        for (int i = 0; i < ticks; i++) begin
            case ($urandom_range(0, 19))
                0: r = mk(KIND_PAUSE, 16'd0);
                1: r = mk(KIND_PLAY, 16'd0);
                2: r = mk(KIND_RESET, 16'd0);
                3: r = mk(3'($urandom_range(5, 7)), 16'd0);
                4: begin
                    // out of range load is not possible in 3 bits; reload a slot
                    r = rand_req();
                    r.kind = KIND_LOAD;
                    r.trk = 3'($urandom_range(0, 7));
                    r.idx = 0;
                    r.last = 0;
                    if (!written[r.trk][0]) r.trk = 0;
                    if (!written[r.trk][0]) r.kind = KIND_PAUSE;
                end
                default: r = mk(KIND_TICK, $urandom_range(0, 19) == 0 ?
                                16'hFFFF : 16'($urandom_range(0, 16'h1800)));
            endcase
            pending_reqs.push_back(r);
        end
    endtask

    initial begin
        seq_req_t r;
        ev_count = '{default: 0};
        ev_pos = '{default: 0};
        song_time = 0; loops = 0; playing = 0; played = 0;
        cur_tracks = 0; cur_len = 0; cur_loop_start = 0; cur_limit = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // directed: ticks over empty tracks, an unknown kind
        write_reg(REG_TRACK_COUNT, 32'd2);
        pending_reqs.push_back(mk(KIND_TICK, 16'hFFFF));
        pending_reqs.push_back(mk(3'd7, 16'd0));
        pending_reqs.push_back(mk(KIND_PLAY, 16'd0));
        pending_reqs.push_back(mk(KIND_TICK, 16'h0001));
        drain();
        // full-width single-event track, then a four-event track starting at zero
        write_reg(REG_TRACK_COUNT, 32'd15);
        write_reg(REG_SONG_LENGTH, 32'hFFFF_FFFF);
        write_reg(REG_LOOP_START, 32'd0);
        write_reg(REG_LOOP_LIMIT, 32'd0);
        r = '1; r.kind = KIND_LOAD; r.trk = 3'd7; r.idx = 0; r.last = 1;
        written[7][0] = 1; pending_reqs.push_back(r);
        load_track(0, 4, 32'h800, 1);
        for (int i = 0; i < 6; i++) pending_reqs.push_back(mk(KIND_TICK, 16'hFFFF));
        pending_reqs.push_back(mk(KIND_RESET, 16'd0));
        pending_reqs.push_back(mk(KIND_PAUSE, 16'd0));
        pending_reqs.push_back(mk(KIND_TICK, 16'h0));
        drain();

        // random phases over several song settings
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(REG_TRACK_COUNT, ph == 1 ? 32'd1 : $urandom_range(2, 9));
            write_reg(REG_SONG_LENGTH, ph == 2 ? 32'd0 : $urandom_range(32'h4000, 32'h12000));
            write_reg(REG_LOOP_START, ph == 3 ? 32'hFFFF_FFFF : $urandom_range(0, 32'h6000));
            write_reg(REG_LOOP_LIMIT, ph == 4 ? 32'd255 : $urandom_range(0, 5));
            for (int t = 0; t < NTRK; t++)
                if ($urandom_range(0, 2) != 0 || ph == 0)
                    load_track(t, $urandom_range(1, ph == 5 ? 20 : 8), 32'h2000, 0);
            r = mk(KIND_RESET, 16'd0);
            pending_reqs.push_back(r);
            play_phase(25);
            drain();
        end
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule

[sim.f]
sv/mns_pkg.sv
sv/mns_ram.sv
sv/multitrack_note_sequencer.sv
verif/tb_multitrack_note_sequencer.sv
